// File: sv/bq_pkg.sv
package bq_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_FF0  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FF1  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_FF2  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_FB1  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FB2  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_GAIN = 3'd5;

  localparam int NUM_REGS = 6;

endpackage

// File: sv/bq_sermul.sv
module bq_sermul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  output logic [AW+BW-1:0]     product,
  output bq_pkg::mul_sts_t     sts
);

  localparam int CNTW = $clog2(BW);

  logic [AW-1:0]   a_reg;
  logic [AW:0]     hi;
  logic [BW-1:0]   lo;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;

  logic            last;
  logic [AW:0]     addend;
  logic [AW:0]     psum;

  // The sign bit of the multiplier carries negative weight, so the last step subtracts.
  assign last   = (cnt == '0);
  assign addend = lo[0] ? {a_reg[AW-1], a_reg} : '0;
  assign psum   = last ? (hi - addend) : (hi + addend);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      a_reg <= a;
      hi    <= '0;
      lo    <= b;
      cnt   <= CNTW'(BW - 1);
      busy  <= 1'b1;
      done  <= 1'b0;
    end else if (busy) begin
      hi <= {psum[AW], psum[AW:1]};
      lo <= {psum[0], lo[BW-1:1]};
      if (last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign product  = {hi[AW-1:0], lo};
  assign sts.busy = busy;
  assign sts.done = done;

  assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("multiplier did not start");
  assert property (@(posedge clk) disable iff (rst) !(busy && done))
    else $error("multiplier busy and done together");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy) && $past(last))
    else $error("multiplier done without a final step");

endmodule

// File: sv/bq_apb_regs.sv
module bq_apb_regs #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int CW = 24,
  parameter int DW = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  output logic [CW-1:0] coef_ff0,
  output logic [CW-1:0] coef_ff1,
  output logic [CW-1:0] coef_ff2,
  output logic [CW-1:0] coef_fb1,
  output logic [CW-1:0] coef_fb2,
  output logic [CW-1:0] norm_gain
);

  localparam int IDX_LO = $clog2(DW / 8);

  logic                              wr;
  logic [bq_pkg::REG_IDX_BITS-1:0]   idx;
  logic [CW-1:0]                     wval;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[AW-1:IDX_LO];
  assign wval   = pwdata[CW-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ff0  <= '0;
      coef_ff1  <= '0;
      coef_ff2  <= '0;
      coef_fb1  <= '0;
      coef_fb2  <= '0;
      norm_gain <= CW'(1) << COEF_FRAC_BITS;
    end else if (wr) begin
      case (idx)
        bq_pkg::REG_FF0:  coef_ff0  <= wval;
        bq_pkg::REG_FF1:  coef_ff1  <= wval;
        bq_pkg::REG_FF2:  coef_ff2  <= wval;
        bq_pkg::REG_FB1:  coef_fb1  <= wval;
        bq_pkg::REG_FB2:  coef_fb2  <= wval;
        bq_pkg::REG_GAIN: norm_gain <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bq_pkg::REG_FF0:  prdata = DW'(coef_ff0);
      bq_pkg::REG_FF1:  prdata = DW'(coef_ff1);
      bq_pkg::REG_FF2:  prdata = DW'(coef_ff2);
      bq_pkg::REG_FB1:  prdata = DW'(coef_fb1);
      bq_pkg::REG_FB2:  prdata = DW'(coef_fb2);
      bq_pkg::REG_GAIN: prdata = DW'(norm_gain);
      default:          prdata = '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
      (wr && idx == bq_pkg::REG_GAIN) |=> norm_gain == $past(wval))
    else $error("gain register write lost");
  assert property (@(posedge clk) disable iff (rst)
      !wr |=> $stable(coef_ff0) && $stable(coef_fb1) && $stable(norm_gain))
    else $error("register changed without a write");
  assert property (@(posedge clk) disable iff (rst)
      (wr && idx >= 3'(bq_pkg::NUM_REGS)) |=> $stable(coef_ff0) && $stable(coef_fb2))
    else $error("write beyond the register list took effect");

endmodule

// File: sv/biquad_iir_filter.sv
// Each sample is worked through by the bit-serial shift-add multiplier: five terms of
// COEF_FRAC_BITS+4 steps each, then one step per bit of the sum for the gain. The result
// is then loaded into the output register once that register is free, and the next
// sample can be taken while it waits there, but not before it is loaded. Reset clears
// the history, the coefficients and sets the gain to one.
module biquad_iir_filter #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20,
  localparam int CW  = COEF_FRAC_BITS + 4,
  localparam int DW  = (CW > 32) ? 64 : 32,
  localparam int PAW = $clog2(6 * (DW / 8))
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PAW-1:0]                paddr,
  input  logic [DW-1:0]                 pwdata,
  output logic [DW-1:0]                 prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int SW   = SAMPLE_BITS;
  localparam int TPW  = SW + CW;
  localparam int SUMW = SW + CW + 2;
  localparam int PW   = SUMW + CW;
  localparam int RW   = PW - 2 * COEF_FRAC_BITS + 1;
  localparam int QW   = RW + 1;

  localparam logic [2:0] TERM_X0 = 3'd0;
  localparam logic [2:0] TERM_X1 = 3'd1;
  localparam logic [2:0] TERM_X2 = 3'd2;
  localparam logic [2:0] TERM_Y1 = 3'd3;
  localparam logic [2:0] TERM_Y2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TERM,
    ST_GSTART,
    ST_GAIN,
    ST_SAT
  } state_t;

  state_t state;

  logic [CW-1:0] coef_ff0;
  logic [CW-1:0] coef_ff1;
  logic [CW-1:0] coef_ff2;
  logic [CW-1:0] coef_fb1;
  logic [CW-1:0] coef_fb2;
  logic [CW-1:0] norm_gain;

  logic [SW-1:0]   x_reg;
  logic [SW-1:0]   in_delay1;
  logic [SW-1:0]   in_delay2;
  logic [SW-1:0]   out_delay1;
  logic [SW-1:0]   out_delay2;
  logic [2:0]      k;
  logic [SUMW-1:0] sum;
  logic [QW-1:0]   rnd;

  logic [SW-1:0]    t_a;
  logic [CW-1:0]    t_b;
  logic [TPW-1:0]   tprod;
  logic [SUMW-1:0]  tprod_ext;
  logic [SUMW-1:0]  sum_next;
  logic [PW-1:0]    gprod;
  logic [QW-1:0]    rnd_next;
  logic [RW-1:0]    y;
  logic [SW-1:0]    sat;
  logic             fits;
  logic             t_start;
  logic             g_start;
  logic             out_load;
  bq_pkg::mul_sts_t t_sts;
  bq_pkg::mul_sts_t g_sts;

  bq_apb_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .CW(CW),
    .DW(DW),
    .AW(PAW)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .coef_ff0(coef_ff0),
    .coef_ff1(coef_ff1),
    .coef_ff2(coef_ff2),
    .coef_fb1(coef_fb1),
    .coef_fb2(coef_fb2),
    .norm_gain(norm_gain)
  );

  always_comb begin
    case (k)
      TERM_X0: begin t_a = x_reg;      t_b = coef_ff0; end
      TERM_X1: begin t_a = in_delay1;  t_b = coef_ff1; end
      TERM_X2: begin t_a = in_delay2;  t_b = coef_ff2; end
      TERM_Y1: begin t_a = out_delay1; t_b = coef_fb1; end
      TERM_Y2: begin t_a = out_delay2; t_b = coef_fb2; end
      default: begin t_a = x_reg;      t_b = coef_ff0; end
    endcase
  end

  assign t_start = (state == ST_START);
  assign g_start = (state == ST_GSTART);

  bq_sermul #(
    .AW(SW),
    .BW(CW)
  ) u_term_mul (
    .clk(clk),
    .rst(rst),
    .start(t_start),
    .a(t_a),
    .b(t_b),
    .product(tprod),
    .sts(t_sts)
  );

  bq_sermul #(
    .AW(CW),
    .BW(SUMW)
  ) u_gain_mul (
    .clk(clk),
    .rst(rst),
    .start(g_start),
    .a(norm_gain),
    .b(sum),
    .product(gprod),
    .sts(g_sts)
  );

  assign tprod_ext = {{2{tprod[TPW-1]}}, tprod};
  assign sum_next  = (k inside {TERM_Y1, TERM_Y2}) ? (sum - tprod_ext) : (sum + tprod_ext);

  // Rounding half up: add one at the bit just below the kept part, then drop that bit.
  assign rnd_next = {gprod[PW-1], gprod[PW-1:2*COEF_FRAC_BITS-1]} + QW'(1);
  assign y        = rnd[QW-1:1];
  assign fits     = (&y[RW-1:SW-1]) || !(|y[RW-1:SW-1]);
  assign sat      = fits ? y[SW-1:0]
                  : (y[RW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_SAT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k          <= TERM_X0;
      out_valid  <= 1'b0;
      in_delay1  <= '0;
      in_delay2  <= '0;
      out_delay1 <= '0;
      out_delay2 <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x_reg <= sample_in;
            k     <= TERM_X0;
            sum   <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_TERM;
        end
        ST_TERM: begin
          if (t_sts.done) begin
            sum <= sum_next;
            if (k == TERM_Y2) begin
              state <= ST_GSTART;
            end else begin
              k     <= k + 3'd1;
              state <= ST_START;
            end
          end
        end
        ST_GSTART: begin
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          if (g_sts.done) begin
            rnd   <= rnd_next;
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (out_load) begin
            sample_out <= sat;
            out_valid  <= 1'b1;
            in_delay2  <= in_delay1;
            in_delay1  <= x_reg;
            out_delay2 <= out_delay1;
            out_delay1 <= sat;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !t_sts.busy && !g_sts.busy)
    else $error("sample taken while a multiplier is running");
  assert property (@(posedge clk) disable iff (rst) t_sts.done |-> state == ST_TERM)
    else $error("term product finished outside the term phase");
  assert property (@(posedge clk) disable iff (rst) g_sts.done |-> state == ST_GAIN)
    else $error("gain product finished outside the gain phase");
  assert property (@(posedge clk) disable iff (rst)
      out_load |=> out_valid && out_delay1 == sample_out)
    else $error("fed back value differs from the delivered result");
  assert property (@(posedge clk) disable iff (rst) k <= TERM_Y2)
    else $error("term counter out of range");

endmodule
